// ----- rtl/lcdis_pkg.sv -----
// Shared types and codes for the display init table sequencer.
package lcdis_pkg;

    localparam logic [1:0] PH_CMD   = 2'd0;
    localparam logic [1:0] PH_DELAY = 2'd1;
    localparam logic [1:0] PH_COUNT = 2'd2;
    localparam logic [1:0] PH_DATA  = 2'd3;

    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_DELAY = 2'd2;

    localparam logic [7:0] MARKER_RESET = 8'hFF;

    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

endpackage

// ----- rtl/lcdis_front.sv -----
// Table parser: accepts table bytes, classifies them and pushes command, data and delay entries.
module lcdis_front
    import lcdis_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] table_byte
    input  logic       i_s_tuser,   // [0] start_of_table
    input  logic [7:0] i_marker,
    input  logic       i_q_full,
    output t_push      o_push
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [1:0] w_phase;
    logic [7:0] w_left;
    logic       w_accept;
    logic       w_emit;
    t_entry     w_entry;

    assign o_s_tready = !i_q_full;
    assign w_accept   = i_s_tvalid && !i_q_full;

    always_comb begin
        w_phase      = i_s_tuser ? PH_CMD : r_phase;
        w_left       = i_s_tuser ? 8'd0 : r_bytes_left;
        if (w_phase == PH_DATA && w_left == 8'd0) begin
            w_phase = PH_CMD;
        end
        n_phase       = w_phase;
        n_bytes_left  = w_left;
        w_emit        = 1'b0;
        w_entry.kind  = KIND_CMD;
        w_entry.value = i_s_tdata;
        unique case (w_phase)
            PH_DELAY: begin
                n_phase      = PH_CMD;
                w_emit       = 1'b1;
                w_entry.kind = KIND_DELAY;
            end
            PH_COUNT: begin
                n_bytes_left = i_s_tdata;
                n_phase      = (i_s_tdata == 8'd0) ? PH_CMD : PH_DATA;
            end
            PH_DATA: begin
                n_bytes_left = w_left - 8'd1;
                n_phase      = (w_left == 8'd1) ? PH_CMD : PH_DATA;
                w_emit       = 1'b1;
                w_entry.kind = KIND_DATA;
            end
            default: begin
                if (i_s_tdata == i_marker) begin
                    n_phase = PH_DELAY;
                end else begin
                    n_phase      = PH_COUNT;
                    w_emit       = 1'b1;
                    w_entry.kind = KIND_CMD;
                end
            end
        endcase
    end

    assign o_push.push  = w_accept && w_emit;
    assign o_push.entry = w_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_CMD;
            r_bytes_left <= 8'd0;
        end else if (w_accept) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
        end
    end

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_bytes_left != 8'd0)
        else $error("data phase with no bytes left");

    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.push |-> o_push.entry.kind != 2'd3)
        else $error("invalid entry kind pushed");

endmodule

// ----- rtl/lcdis_queue.sv -----
// Small FIFO between the parser and the output stage.
module lcdis_queue
    import lcdis_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry,
    input  logic   i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (i_push.push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !i_push.push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> !o_full)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

// ----- rtl/lcdis_back.sv -----
// Output register stage driving the result stream.
module lcdis_back
    import lcdis_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_entry     i_q_entry,
    output logic       o_q_pop,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_value
    output logic [1:0] o_m_tuser    // [1:0] out_kind
);

    logic   r_valid;
    t_entry r_entry;
    logic   w_load;

    assign w_load  = i_q_valid && (!r_valid || i_m_tready);
    assign o_q_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_m_tready) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_entry <= i_q_entry;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_entry.value;
    assign o_m_tuser  = r_entry.kind;

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_m_tready) |-> !o_q_pop)
        else $error("queue popped while output stalled");

endmodule

// ----- rtl/lcd_init_table_sequencer.sv -----
// Top level of the display init table sequencer.
//
//  channel   dir  handshake             payload
//  s stream  in   i_s_tvalid/o_s_tready tdata=table_byte, tuser=start_of_table
//  m stream  out  o_m_tvalid/i_m_tready tdata=out_value,  tuser=out_kind
//  apb       in   psel/penable/pwrite   reg 0 delay_marker at 0x0
//
//  One table byte per cycle while the queue is not full; each accepted byte updates phase and count.
//  An emitted entry is registered in the queue, then in the output register that drives o_m_tvalid.
//  Output stalls fill the queue; o_s_tready drops only when it is full.
//  Synchronous reset clears phase, count, queue and output valid; marker to 0xFF.
module lcd_init_table_sequencer
    import lcdis_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] table_byte
    input  logic        i_s_tuser,   // [0] start_of_table
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_value
    output logic [1:0]  o_m_tuser,   // [1:0] out_kind
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic [7:0] r_marker;
    t_push      w_push;
    logic       w_full;
    logic       w_q_valid;
    t_entry     w_q_entry;
    logic       w_pop;

    assign o_pready = 1'b1;
    assign o_prdata = i_paddr[2] ? 32'd0 : {24'd0, r_marker};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= MARKER_RESET;
        end else if (i_psel && i_penable && i_pwrite && !i_paddr[2]) begin
            r_marker <= i_pwdata[7:0];
        end
    end

    lcdis_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_marker   (r_marker),
        .i_q_full   (w_full),
        .o_push     (w_push)
    );

    lcdis_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    lcdis_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_entry  (w_q_entry),
        .o_q_pop    (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
